### hw/rtl/ffba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ffba_pkg;

  localparam int unsigned TableDepth  = 16;
  localparam int unsigned AddrBits    = 32;
  localparam int unsigned HeaderBytes = 16;
  localparam int unsigned NodeBytes   = 16;

  localparam int unsigned IdxW    = $clog2(TableDepth);
  localparam int unsigned CntW    = $clog2(TableDepth + 1);
  localparam int unsigned EntryW  = 32;
  localparam int unsigned SizeW   = 24;
  localparam int unsigned ShiftW  = 5;
  localparam int unsigned RoundW  = 32;
  localparam int unsigned RegionW = RoundW + 1;
  localparam int unsigned PtrW    = AddrBits + 1;
  localparam int unsigned SumW    = ((PtrW > RegionW) ? PtrW : RegionW) + 1;
  localparam int unsigned RestW   = SumW + 1;

  localparam logic [ShiftW-1:0] PageShiftReset = ShiftW'(12);

  typedef struct packed {
    logic start;
    logic scan_step;
    logic take_hit;
    logic calc_region;
    logic fresh_commit;
    logic finish_rest;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic scan_end;
    logic scan_match;
    logic fresh_fail;
  } stat_t;

endpackage

`default_nettype wire

### hw/rtl/ffba_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module ffba_ctrl
  import ffba_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  input  wire logic  out_ready_i,
  output logic       out_valid_o,
  input  wire stat_t stat_i,
  output cmd_t       cmd_o
);

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StScan   = 3'd1;
  localparam logic [2:0] StRegion = 3'd2;
  localparam logic [2:0] StCheck  = 3'd3;
  localparam logic [2:0] StRest   = 3'd4;
  localparam logic [2:0] StOut    = 3'd5;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = StScan;
        end
      end
      StScan: begin
        if (stat_i.scan_end) begin
          state_d = StRegion;
        end else if (stat_i.scan_match) begin
          cmd_o.take_hit = 1'b1;
          state_d        = StRest;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      StRegion: begin
        cmd_o.calc_region = 1'b1;
        state_d           = StCheck;
      end
      StCheck: begin
        cmd_o.fresh_commit = 1'b1;
        state_d            = stat_i.fresh_fail ? StOut : StRest;
      end
      StRest: begin
        cmd_o.finish_rest = 1'b1;
        state_d           = StOut;
      end
      StOut: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

### hw/rtl/ffba_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module ffba_dp
  import ffba_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [ShiftW-1:0] cfg_wdata_i,
  input  wire logic [SizeW-1:0]  request_size_i,
  input  wire cmd_t              cmd_i,
  output stat_t                  stat_o,
  output logic [31:0]            block_address_o,
  output logic                   from_free_table_o,
  output logic                   remainder_kept_o,
  output logic                   remainder_dropped_o,
  output logic                   status_o
);

  logic [EntryW-1:0]  start_q [TableDepth];
  logic [EntryW-1:0]  len_q   [TableDepth];
  logic [CntW-1:0]    count_q;
  logic [PtrW-1:0]    fresh_ptr_q;
  logic [ShiftW-1:0]  page_shift_q;

  logic [SizeW-1:0]   size_q;
  logic [CntW-1:0]    idx_q;
  logic [RegionW-1:0] region_q;
  logic [PtrW-1:0]    base_q;
  logic [RegionW-1:0] blen_q;
  logic               hit_q, kept_q, dropped_q, fail_q;

  logic [IdxW-1:0]    rd_idx;
  logic [EntryW-1:0]  rd_len;
  logic [RoundW-1:0]  page_mask;
  logic [RoundW-1:0]  rounded;
  logic [SumW-1:0]    fresh_end;
  logic [SumW-1:0]    limit;
  logic [RestW-1:0]   rest;
  logic               rest_ok;
  logic               table_full;
  logic [PtrW-1:0]    rem_start;
  logic [PtrW-1:0]    addr_full;

  assign rd_idx = idx_q[IdxW-1:0];
  assign rd_len = len_q[rd_idx];

  assign stat_o.scan_end   = (idx_q == count_q);
  assign stat_o.scan_match = (rd_len >= EntryW'(size_q));

  assign page_mask = (RoundW'(1) << page_shift_q) - RoundW'(1);
  assign rounded   = (RoundW'(size_q) + page_mask) & ~page_mask;

  assign limit             = SumW'(1) << AddrBits;
  assign fresh_end         = SumW'(fresh_ptr_q) + SumW'(region_q);
  assign stat_o.fresh_fail = (fresh_end > limit);

  assign rest = RestW'(blen_q) - RestW'(size_q) - RestW'(2 * HeaderBytes);
  assign rest_ok    = !rest[RestW-1] && (rest >= RestW'(NodeBytes));
  assign table_full = (count_q >= CntW'(TableDepth));
  assign rem_start  = base_q + PtrW'(HeaderBytes) + PtrW'(size_q);
  assign addr_full  = base_q + PtrW'(HeaderBytes);

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_hit) begin
      for (int i = 0; i < TableDepth - 1; i++) begin
        if (IdxW'(i) >= rd_idx) begin
          start_q[i] <= start_q[i+1];
          len_q[i]   <= len_q[i+1];
        end
      end
    end else if (cmd_i.finish_rest && rest_ok && !table_full) begin
      for (int i = 1; i < TableDepth; i++) begin
        start_q[i] <= start_q[i-1];
        len_q[i]   <= len_q[i-1];
      end
      start_q[0] <= rem_start[EntryW-1:0];
      len_q[0]   <= rest[EntryW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      fresh_ptr_q  <= '0;
      page_shift_q <= PageShiftReset;
    end else begin
      if (cfg_we_i) begin
        page_shift_q <= cfg_wdata_i;
      end
      if (cmd_i.take_hit) begin
        count_q <= count_q - CntW'(1);
      end else if (cmd_i.finish_rest && rest_ok && !table_full) begin
        count_q <= count_q + CntW'(1);
      end
      if (cmd_i.fresh_commit && !stat_o.fresh_fail) begin
        fresh_ptr_q <= fresh_end[PtrW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      size_q    <= request_size_i;
      idx_q     <= '0;
      hit_q     <= 1'b0;
      kept_q    <= 1'b0;
      dropped_q <= 1'b0;
      fail_q    <= 1'b0;
    end
    if (cmd_i.scan_step) begin
      idx_q <= idx_q + CntW'(1);
    end
    if (cmd_i.take_hit) begin
      base_q <= PtrW'(start_q[rd_idx]);
      blen_q <= RegionW'(rd_len);
      hit_q  <= 1'b1;
    end
    if (cmd_i.calc_region) begin
      region_q <= {rounded, 1'b0};
    end
    if (cmd_i.fresh_commit) begin
      if (stat_o.fresh_fail) begin
        fail_q <= 1'b1;
      end else begin
        base_q <= fresh_ptr_q;
        blen_q <= region_q;
      end
    end
    if (cmd_i.finish_rest && rest_ok) begin
      kept_q    <= !table_full;
      dropped_q <= table_full;
    end
    if (cmd_i.load_out) begin
      block_address_o     <= fail_q ? 32'd0 : addr_full[31:0];
      from_free_table_o   <= hit_q && !fail_q;
      remainder_kept_o    <= kept_q && !fail_q;
      remainder_dropped_o <= dropped_q && !fail_q;
      status_o            <= fail_q;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/first_fit_block_allocator.sv
// First-fit block allocator.
// A request transfer on the input channel (in_valid_i/in_ready_o) carries a
// request size in bytes. The block searches its free table from the front for
// the first entry large enough, removes it and keeps the order of the rest; if
// none fits it carves a fresh region, rounded to pages and doubled, from a
// bump pointer. A usable leftover is pushed at the front of the table.
// Each request yields one result transfer on the output channel
// (out_valid_o/out_ready_i) with the address, the flags and the status.
// The block works on one request at a time. The table scan examines one
// entry per cycle from the front. On a hit the entry is taken; otherwise a
// fresh region is sized and checked against the top of the address space,
// then committed or refused. A usable leftover is kept, or dropped when the
// table is full. A new request is taken once the result is in the output
// register. The page shift register must be written by the user through
// cfg_we_i/cfg_wdata_i only while idle; the block itself does not enforce it.
// Reset empties the table, clears the bump pointer and sets the page shift
// to 12. A finished result waits in the output register while the receiver
// stalls; a new request is taken meanwhile, but its result waits until the
// previous one has been taken.
`timescale 1ns / 1ps
`default_nettype none

module first_fit_block_allocator
  import ffba_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [ShiftW-1:0] cfg_wdata_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [SizeW-1:0]  request_size_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [31:0]            block_address_o,
  output logic                   from_free_table_o,
  output logic                   remainder_kept_o,
  output logic                   remainder_dropped_o,
  output logic                   status_o
);

  cmd_t  cmd;
  stat_t stat;

  ffba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  ffba_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .request_size_i      (request_size_i),
    .cmd_i               (cmd),
    .stat_o              (stat),
    .block_address_o     (block_address_o),
    .from_free_table_o   (from_free_table_o),
    .remainder_kept_o    (remainder_kept_o),
    .remainder_dropped_o (remainder_dropped_o),
    .status_o            (status_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while another is in progress");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> !from_free_table_o && !remainder_kept_o &&
      !remainder_dropped_o && (block_address_o == 32'd0))
    else $error("refused request reports a grant");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(remainder_kept_o && remainder_dropped_o))
    else $error("leftover both kept and dropped");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && from_free_table_o |-> !remainder_dropped_o)
    else $error("leftover dropped after a table hit");

endmodule

`default_nettype wire

### dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import ffba_pkg::*;

  localparam int unsigned CycleLimit = 600_000;
  localparam int unsigned DrainCycles = 40;
  localparam logic [SizeW-1:0] MaxSize = '1;

  typedef struct packed {
    logic [31:0] addr;
    logic        from_table;
    logic        kept;
    logic        dropped;
    logic        status;
  } alloc_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [ShiftW-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic [SizeW-1:0] req_size = '0;
  logic out_ready = 1'b0;

  logic in_ready_o;
  logic out_valid_o;
  logic [31:0] block_address_o;
  logic from_free_table_o;
  logic remainder_kept_o;
  logic remainder_dropped_o;
  logic status_o;

  logic [31:0] tbl_start [TableDepth];
  logic [31:0] tbl_len [TableDepth];
  int tbl_count = 0;
  logic [PtrW-1:0] bump_ptr = '0;
  logic [ShiftW-1:0] shift_cfg = PageShiftReset;

  alloc_result_t pending_allocs [$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int errors = 0;
  int result_count = 0;
  int hit_count = 0;
  int refused_count = 0;
  int unsigned cycle_count = 0;

  first_fit_block_allocator DUT (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_we_i           (cfg_we),
    .cfg_wdata_i        (cfg_wdata),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready_o),
    .request_size_i     (req_size),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready),
    .block_address_o    (block_address_o),
    .from_free_table_o  (from_free_table_o),
    .remainder_kept_o   (remainder_kept_o),
    .remainder_dropped_o(remainder_dropped_o),
    .status_o           (status_o)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Cycle limit reached with %0d results outstanding.", pending_allocs.size());
      $display("Verification failed");
      $finish;
    end
  end

  task automatic predict_allocation(input logic [SizeW-1:0] size, output alloc_result_t res);
    logic [63:0] base;
    logic [63:0] blen;
    logic [63:0] page;
    logic [63:0] region;
    logic [63:0] limit;
    longint rest;
    int hit_idx;
    res = '0;
    base = '0;
    blen = '0;
    hit_idx = -1;
    for (int i = 0; i < tbl_count; i++) begin
      if (hit_idx < 0 && tbl_len[i] >= size) hit_idx = i;
    end
    if (hit_idx >= 0) begin
      base = tbl_start[hit_idx];
      blen = tbl_len[hit_idx];
      for (int i = hit_idx; i + 1 < tbl_count; i++) begin
        tbl_start[i] = tbl_start[i + 1];
        tbl_len[i] = tbl_len[i + 1];
      end
      tbl_count--;
      res.from_table = 1'b1;
    end else begin
      page = 64'd1 << shift_cfg;
      region = (((64'(size) + page - 64'd1) >> shift_cfg) << shift_cfg) * 64'd2;
      limit = 64'd1 << AddrBits;
      if (64'(bump_ptr) > limit || region > limit - 64'(bump_ptr)) begin
        res.status = 1'b1;
        return;
      end
      base = 64'(bump_ptr);
      blen = region;
      bump_ptr = PtrW'(64'(bump_ptr) + region);
    end
    rest = longint'(blen) - longint'(size) - longint'(2 * HeaderBytes);
    if (rest >= longint'(NodeBytes)) begin
      if (tbl_count < TableDepth) begin
        for (int i = tbl_count; i > 0; i--) begin
          tbl_start[i] = tbl_start[i - 1];
          tbl_len[i] = tbl_len[i - 1];
        end
        tbl_start[0] = 32'(base + 64'(HeaderBytes) + 64'(size));
        tbl_len[0] = 32'(rest);
        tbl_count++;
        res.kept = 1'b1;
      end else begin
        res.dropped = 1'b1;
      end
    end
    res.addr = 32'(base + 64'(HeaderBytes));
  endtask

  task automatic send_request(input logic [SizeW-1:0] size);
    alloc_result_t res;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    req_size <= size;
    do @(posedge clk); while (!in_ready_o);
    predict_allocation(size, res);
    pending_allocs.push_back(res);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_allocs.size() != 0) @(posedge clk);
  endtask

  task automatic write_page_shift(input logic [ShiftW-1:0] value);
    wait_for_results();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    shift_cfg = value;
  endtask

  task automatic compare_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  task automatic check_result();
    alloc_result_t want;
    if (pending_allocs.size() == 0) begin
      $display("%0t: result transfer with none expected, expected nothing actual address %h",
               $time, block_address_o);
      errors++;
      return;
    end
    want = pending_allocs.pop_front();
    result_count++;
    if (want.from_table) hit_count++;
    if (want.status) refused_count++;
    compare_field("block_address", want.addr, block_address_o);
    compare_field("from_free_table", 32'(want.from_table), 32'(from_free_table_o));
    compare_field("remainder_kept", 32'(want.kept), 32'(remainder_kept_o));
    compare_field("remainder_dropped", 32'(want.dropped), 32'(remainder_dropped_o));
    compare_field("status", 32'(want.status), 32'(status_o));
  endtask

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) check_result();
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic logic [SizeW-1:0] random_size();
    int unsigned roll;
    logic [31:0] fit;
    roll = $urandom_range(99);
    if (tbl_count > 0 && roll < 30) begin
      fit = tbl_len[$urandom_range(tbl_count - 1)];
      if (fit > MaxSize) fit = MaxSize;
      case ($urandom_range(2))
        0: return SizeW'(fit);
        1: return SizeW'($urandom_range(fit));
        default: return (fit > 48) ? SizeW'(fit - 48 + $urandom_range(32)) : SizeW'(fit);
      endcase
    end
    if (roll < 65) return SizeW'($urandom_range(255));
    if (roll < 87) return SizeW'($urandom_range(65535));
    if (roll < 97) return SizeW'($urandom_range(1 << 20));
    return SizeW'($urandom());
  endfunction

  task automatic drain_free_table();
    while (tbl_count > 0) begin
      send_request((tbl_len[0] > MaxSize) ? MaxSize : SizeW'(tbl_len[0]));
    end
  endtask

  task automatic test_directed_corners();
    send_idle_pct = 37;
    recv_idle_pct = 66;
    // A zero request with an empty table takes a zero-sized fresh region.
    send_request('0);
    send_request('0);
    send_request(SizeW'(1));
    send_request(MaxSize);
    send_request(SizeW'(8159));
    send_request(SizeW'(100));
    send_request('0);
    write_page_shift(ShiftW'(4));
    send_request(SizeW'(17));
    send_request(SizeW'(16));
    send_request(SizeW'(24'h5A5A5A));
    write_page_shift(ShiftW'(16));
    send_request(SizeW'(65536));
    send_request(SizeW'(24'hA5A5A5));
    write_page_shift(ShiftW'(0));
    send_request(SizeW'(3));
    send_request(MaxSize);
    write_page_shift(ShiftW'(31));
    send_request(MaxSize);
    write_page_shift(ShiftW'(20));
    send_request(SizeW'(1));
  endtask

  task automatic test_random_traffic(input int unsigned send_pct, recv_pct, n_items,
                                     input logic [ShiftW-1:0] shift, input bit pause_midway);
    write_page_shift(shift);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int n = 0; n < n_items; n++) begin
      if (pause_midway && n == n_items / 2) wait_for_results();
      send_request(random_size());
    end
  endtask

  task automatic test_address_exhaustion();
    longint unsigned room;
    int k;
    send_idle_pct = 20;
    recv_idle_pct = 20;
    drain_free_table();
    // Fill the table with short entries so that later leftovers are dropped.
    write_page_shift(ShiftW'(0));
    repeat (TableDepth + 1) send_request(SizeW'(64));
    write_page_shift(ShiftW'(31));
    send_request(SizeW'(64));
    room = (64'd1 << AddrBits) - 64'(bump_ptr);
    while (room > 2 * 64'(MaxSize)) begin
      k = 0;
      while ((64'd1 << (k + 2)) <= room / 2) k++;
      write_page_shift(ShiftW'(k));
      send_request(SizeW'(64));
      room = (64'd1 << AddrBits) - 64'(bump_ptr);
    end
    if (room > 64) begin
      write_page_shift(ShiftW'(0));
      send_request(SizeW'(room / 2));
    end
    write_page_shift(ShiftW'(12));
    send_request(SizeW'(100));
    drain_free_table();
    send_request('0);
    send_request(SizeW'(1));
    send_request('0);
    write_page_shift(ShiftW'(4));
    send_request(MaxSize);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_corners();
    test_random_traffic(37, 66, 150, ShiftW'(4), 1'b1);
    test_random_traffic(66, 37, 150, ShiftW'(16), 1'b0);
    repeat (3) test_random_traffic(0, 0, 50, ShiftW'($urandom_range(20)), 1'b0);
    test_address_exhaustion();
    in_valid <= 1'b0;
    while (pending_allocs.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    $display("Checked %0d allocations: %0d from the free table, %0d refused for lack of space.",
             result_count, hit_count, refused_count);
    $display("Page shifts 0 to 31, three idle mixes and a fill to the top of memory were run.");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/ffba_pkg.sv
hw/rtl/ffba_ctrl.sv
hw/rtl/ffba_dp.sv
hw/rtl/first_fit_block_allocator.sv
dv/tb.sv
